### design/cagd_pkg.sv
// Shared types and constants of the cloud automaton block.
package cagd_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_GROW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Bit positions within one bank's flag triple.
  localparam int FLAG_HUM = 0;
  localparam int FLAG_ACT = 1;
  localparam int FLAG_CLD = 2;

  // Number of neighbours that feed the activation factor.
  localparam int GROW_TAPS = 11;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    logic signed [2:0] dz;
  } offset_t;

  // Neighbour offsets of the activation factor; there is no tap at z+2.
  function automatic offset_t grow_offset(input logic [3:0] idx);
    offset_t o;
    o = '0;
    case (idx)
      4'd0:    o = '{dx:  3'sd1, dy:  3'sd0, dz:  3'sd0};
      4'd1:    o = '{dx: -3'sd1, dy:  3'sd0, dz:  3'sd0};
      4'd2:    o = '{dx:  3'sd0, dy:  3'sd1, dz:  3'sd0};
      4'd3:    o = '{dx:  3'sd0, dy: -3'sd1, dz:  3'sd0};
      4'd4:    o = '{dx:  3'sd0, dy:  3'sd0, dz:  3'sd1};
      4'd5:    o = '{dx:  3'sd0, dy:  3'sd0, dz: -3'sd1};
      4'd6:    o = '{dx:  3'sd2, dy:  3'sd0, dz:  3'sd0};
      4'd7:    o = '{dx: -3'sd2, dy:  3'sd0, dz:  3'sd0};
      4'd8:    o = '{dx:  3'sd0, dy:  3'sd2, dz:  3'sd0};
      4'd9:    o = '{dx:  3'sd0, dy: -3'sd2, dz:  3'sd0};
      4'd10:   o = '{dx:  3'sd0, dy:  3'sd0, dz: -3'sd2};
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

### design/cloud_automaton_growth_density.sv
// Top level of the cloud automaton: cell store, growth sequencer and density readout.
//
// Usage. A transaction is accepted at a rising edge where start is high and busy is
// low. in_kind selects a cell write, one growth generation over the whole grid, or a
// cell read. Every transaction, whatever its kind, produces exactly one result: the
// addressed cell's shape and current-bank flags, and its density (the number of
// cloud bits in its 3x3x3 neighbourhood, or zero when the cell is outside the shape
// or the coordinate lies off the grid). The result is shown for one cycle with
// out_valid high; the receiver cannot stall, so it must take it then.
// Sequence. For a read or write the strobe follows one centre read and 27 neighbour
// reads through the single memory read port, then pipeline fill and the output
// register. A growth generation visits each cell in turn (a centre read, 11 factor
// reads, drain and write-back) and is followed by the readout of the addressed cell.
// The memory port is the limit: one neighbour is fetched per cycle. busy falls in the
// cycle that shows the result, so the next transaction can be taken at the edge that
// ends it.
// Reset. After rst_n is released the sequencer sweeps the memory once, clearing one
// cell per cycle across all GRID_LEN * GRID_WID * GRID_HGT cells (2048 by default);
// busy is high throughout and no transaction is taken.
module cloud_automaton_growth_density
  import cagd_pkg::*;
#(
  parameter int GRID_LEN = 16,
  parameter int GRID_WID = 16,
  parameter int GRID_HGT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [3:0] in_cell_x,
  input  logic [3:0] in_cell_y,
  input  logic [2:0] in_cell_z,
  input  logic       in_shape,
  input  logic       in_humid,
  input  logic       in_active,
  input  logic       in_cloudy,
  output logic       out_valid,
  output logic [4:0] out_density_count,
  output logic       out_shape_out,
  output logic       out_humid_out,
  output logic       out_active_out,
  output logic       out_cloudy_out
);

  localparam int CELLS = GRID_LEN * GRID_WID * GRID_HGT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_LEN);
  localparam int YW    = $clog2(GRID_WID);
  localparam int ZW    = $clog2(GRID_HGT);
  localparam int MAXD  = (GRID_LEN > GRID_WID) ?
                         ((GRID_LEN > GRID_HGT) ? GRID_LEN : GRID_HGT) :
                         ((GRID_WID > GRID_HGT) ? GRID_WID : GRID_HGT);
  // Coordinates are signed so that offsets past the edge can be tested.
  localparam int CW    = ($clog2(MAXD) + 2 > 5) ? $clog2(MAXD) + 2 : 5;

  // Word layout: shape, bank one flags, bank zero flags.
  localparam int WW    = 7;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_R_CTR = 4'd2;
  localparam logic [3:0] ST_R_NB  = 4'd3;
  localparam logic [3:0] ST_R_FIN = 4'd4;
  localparam logic [3:0] ST_R_OUT = 4'd5;
  localparam logic [3:0] ST_G_CTR = 4'd6;
  localparam logic [3:0] ST_G_NB  = 4'd7;
  localparam logic [3:0] ST_G_FIN = 4'd8;
  localparam logic [3:0] ST_G_WR  = 4'd9;

  // What the returning read data is used for.
  localparam logic [1:0] TAG_CTR = 2'd0;
  localparam logic [1:0] TAG_CNT = 2'd1;
  localparam logic [1:0] TAG_ACT = 2'd2;

  typedef logic signed [CW-1:0] coord_t;

  function automatic logic [AW-1:0] cell_addr(input coord_t x, input coord_t y,
                                               input coord_t z);
    return AW'(int'(x) * (GRID_WID * GRID_HGT) + int'(y) * GRID_HGT + int'(z));
  endfunction

  logic [3:0]    state_r, state_nxt;
  logic          bank_r, bank_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  coord_t        tx_r, ty_r, tz_r;
  logic [XW-1:0] gx_r, gx_nxt;
  logic [YW-1:0] gy_r, gy_nxt;
  logic [ZW-1:0] gz_r, gz_nxt;
  logic signed [1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [3:0]    gidx_r, gidx_nxt;

  logic          pend_r, pend_nxt;
  logic [1:0]    tag_r, tag_nxt;
  logic [WW-1:0] mem_q_r;
  logic [WW-1:0] ctr_r;
  logic [4:0]    acc_r;
  logic          fac_r;

  logic [WW-1:0] mem [CELLS];
  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic          re;
  logic          probe_en;
  logic          probe_clr;

  logic          out_valid_r;
  logic [4:0]    out_density_r;
  logic [3:0]    out_bits_r;

  coord_t        in_x, in_y, in_z;
  logic          in_ok;
  coord_t        bx, by, bz, ox, oy, oz, px, py, pz;
  logic          p_in;
  logic [AW-1:0] raddr;
  offset_t       goff;
  logic [2:0]    old_f, new_f;
  logic          q_cld, q_act;
  logic          dens_last, cell_last;

  assign in_x  = coord_t'(in_cell_x);
  assign in_y  = coord_t'(in_cell_y);
  assign in_z  = coord_t'(in_cell_z);
  assign in_ok = (in_x < GRID_LEN) && (in_y < GRID_WID) && (in_z < GRID_HGT);

  assign goff  = grow_offset(gidx_r);
  assign q_cld = bank_r ? mem_q_r[3 + FLAG_CLD] : mem_q_r[FLAG_CLD];
  assign q_act = bank_r ? mem_q_r[3 + FLAG_ACT] : mem_q_r[FLAG_ACT];
  assign old_f = bank_r ? ctr_r[5:3] : ctr_r[2:0];

  // Next generation of one cell, from its own old flags and the factor.
  always_comb begin
    new_f           = '0;
    new_f[FLAG_ACT] = !old_f[FLAG_ACT] && old_f[FLAG_HUM] && fac_r;
    new_f[FLAG_HUM] = old_f[FLAG_HUM] && !old_f[FLAG_ACT];
    new_f[FLAG_CLD] = old_f[FLAG_CLD] || old_f[FLAG_ACT];
  end

  assign dens_last = (dx_r == 2'sd1) && (dy_r == 2'sd1) && (dz_r == 2'sd1);
  assign cell_last = (gx_r == XW'(GRID_LEN - 1)) && (gy_r == YW'(GRID_WID - 1)) &&
                     (gz_r == ZW'(GRID_HGT - 1));

  // Probe address: a base cell plus an offset, checked against the grid.
  always_comb begin
    if (state_r == ST_G_CTR || state_r == ST_G_NB) begin
      bx = coord_t'(gx_r);
      by = coord_t'(gy_r);
      bz = coord_t'(gz_r);
    end else begin
      bx = tx_r;
      by = ty_r;
      bz = tz_r;
    end
    ox = '0;
    oy = '0;
    oz = '0;
    if (state_r == ST_R_NB) begin
      ox = coord_t'(dx_r);
      oy = coord_t'(dy_r);
      oz = coord_t'(dz_r);
    end else if (state_r == ST_G_NB) begin
      ox = coord_t'(goff.dx);
      oy = coord_t'(goff.dy);
      oz = coord_t'(goff.dz);
    end
    px    = bx + ox;
    py    = by + oy;
    pz    = bz + oz;
    p_in  = (px >= 0) && (px < GRID_LEN) && (py >= 0) && (py < GRID_WID) &&
            (pz >= 0) && (pz < GRID_HGT);
    raddr = cell_addr(px, py, pz);
  end

  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    clr_nxt   = clr_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    gz_nxt    = gz_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    dz_nxt    = dz_r;
    gidx_nxt  = gidx_r;
    probe_en  = 1'b0;
    probe_clr = 1'b0;
    tag_nxt   = TAG_CTR;
    we        = 1'b0;
    waddr     = cell_addr(in_x, in_y, in_z);
    wdata     = {in_shape, in_cloudy, in_active, in_humid, in_cloudy, in_active, in_humid};
    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          we = (in_kind == KIND_WRITE) && in_ok;
          gx_nxt = '0;
          gy_nxt = '0;
          gz_nxt = '0;
          state_nxt = (in_kind == KIND_GROW) ? ST_G_CTR : ST_R_CTR;
        end
      end
      ST_R_CTR: begin
        probe_en  = 1'b1;
        probe_clr = 1'b1;
        tag_nxt   = TAG_CTR;
        dx_nxt    = -2'sd1;
        dy_nxt    = -2'sd1;
        dz_nxt    = -2'sd1;
        state_nxt = ST_R_NB;
      end
      ST_R_NB: begin
        probe_en = 1'b1;
        tag_nxt  = TAG_CNT;
        dz_nxt   = dz_r + 2'sd1;
        if (dz_r == 2'sd1) begin
          dz_nxt = -2'sd1;
          dy_nxt = dy_r + 2'sd1;
          if (dy_r == 2'sd1) begin
            dy_nxt = -2'sd1;
            dx_nxt = dx_r + 2'sd1;
          end
        end
        if (dens_last) begin
          state_nxt = ST_R_FIN;
        end
      end
      ST_R_FIN: begin
        state_nxt = ST_R_OUT;
      end
      ST_R_OUT: begin
        state_nxt = ST_IDLE;
      end
      ST_G_CTR: begin
        probe_en  = 1'b1;
        probe_clr = 1'b1;
        tag_nxt   = TAG_CTR;
        gidx_nxt  = '0;
        state_nxt = ST_G_NB;
      end
      ST_G_NB: begin
        probe_en = 1'b1;
        tag_nxt  = TAG_ACT;
        gidx_nxt = gidx_r + 4'd1;
        if (gidx_r == 4'(GROW_TAPS - 1)) begin
          state_nxt = ST_G_FIN;
        end
      end
      ST_G_FIN: begin
        state_nxt = ST_G_WR;
      end
      ST_G_WR: begin
        // Only the other bank changes; the rest of the word is written back as read.
        we    = ctr_r[WW-1];
        waddr = cell_addr(coord_t'(gx_r), coord_t'(gy_r), coord_t'(gz_r));
        wdata = bank_r ? {ctr_r[6:3], new_f} : {ctr_r[6], new_f, ctr_r[2:0]};
        gz_nxt = gz_r + 1'b1;
        if (gz_r == ZW'(GRID_HGT - 1)) begin
          gz_nxt = '0;
          gy_nxt = gy_r + 1'b1;
          if (gy_r == YW'(GRID_WID - 1)) begin
            gy_nxt = '0;
            gx_nxt = gx_r + 1'b1;
          end
        end
        if (cell_last) begin
          bank_nxt  = !bank_r;
          state_nxt = ST_R_CTR;
        end else begin
          state_nxt = ST_G_CTR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign re       = probe_en && p_in;
  assign pend_nxt = re;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bank_r      <= 1'b0;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= (state_r == ST_R_OUT);
    end
  end

  always_ff @(posedge clk) begin
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    gz_r   <= gz_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    gidx_r <= gidx_nxt;
    tag_r  <= tag_nxt;
    if (state_r == ST_IDLE && start) begin
      tx_r <= in_x;
      ty_r <= in_y;
      tz_r <= in_z;
    end
    // A fresh centre probe clears the gathered values; an off-grid centre stays zero.
    if (probe_clr) begin
      ctr_r <= '0;
      acc_r <= '0;
      fac_r <= 1'b0;
    end else if (pend_r) begin
      case (tag_r)
        TAG_CTR: ctr_r <= mem_q_r;
        TAG_CNT: acc_r <= acc_r + {4'd0, q_cld};
        TAG_ACT: fac_r <= fac_r | q_act;
        default: ctr_r <= ctr_r;
      endcase
    end
    if (state_r == ST_R_OUT) begin
      out_density_r <= ctr_r[WW-1] ? acc_r : 5'd0;
      out_bits_r    <= {ctr_r[WW-1], bank_r ? ctr_r[5:3] : ctr_r[2:0]};
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_density_count = out_density_r;
  assign out_shape_out     = out_bits_r[3];
  assign out_cloudy_out    = out_bits_r[FLAG_CLD];
  assign out_active_out    = out_bits_r[FLAG_ACT];
  assign out_humid_out     = out_bits_r[FLAG_HUM];

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_density_count <= 5'd27)
    else $error("density above neighbourhood size");

  a_unshaped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_shape_out) |-> out_density_count == 5'd0)
    else $error("density reported for a cell outside the shape");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

endmodule
